@@ rtl/core/tes_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tes_pkg;

  localparam int ACTION_W = 2;
  localparam int SLOT_W = 4;
  localparam int TIME_W = 32;
  localparam int DEF_NUM_TIMERS = 16;

  // A tick reports at most this many timers; the rest stay due.
  localparam int MAX_OUT = 16;
  localparam int OUT_CW = $clog2(MAX_OUT + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_ARM    = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_TICK   = 2'd2
  } action_t;

  // One slot of the timer table as it sits in memory.
  typedef struct packed {
    logic [TIME_W-1:0] trigger;
    logic [TIME_W-1:0] period;
    logic              repeats;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/tes_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/timer_expiry_scheduler.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_ready      action, slot, interval, repeat_req, now
// result    out        result_valid / result_ready  fired_valid, fired_slot, last
//
// Arm, delete and unused codes give no beat. A tick gives one beat per fired timer, or a
// single empty beat when none fires: every report is one full pass over the slot memory
// through its single read port, followed by a decide state that writes a repeating
// chosen slot back.
// Reset is synchronous and clears the active marks, the stamp counter and control state.
// A stalled result holds the scan in its decide cycle; items are taken only when idle.

module timer_expiry_scheduler #(
  parameter int NUM_TIMERS = tes_pkg::DEF_NUM_TIMERS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic [tes_pkg::ACTION_W-1:0]  action,
  input  logic [tes_pkg::SLOT_W-1:0]    slot,
  input  logic [tes_pkg::TIME_W-1:0]    interval,
  input  logic                          repeat_req,
  input  logic [tes_pkg::TIME_W-1:0]    now,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic                          fired_valid,
  output logic [tes_pkg::SLOT_W-1:0]    fired_slot,
  output logic                          last
);

  import tes_pkg::*;

  localparam int IW = $clog2(NUM_TIMERS);
  localparam int SCW = $clog2(NUM_TIMERS + 1);
  localparam int ENTRY_W = $bits(entry_t);
  localparam int CMPW = (SCW > OUT_CW) ? SCW : OUT_CW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_t;

  state_t state;

  logic [NUM_TIMERS-1:0] active;
  logic [NUM_TIMERS-1:0] done;
  logic [TIME_W-1:0]     stamp_counter;
  logic [TIME_W-1:0]     now_q;

  logic [SCW-1:0]    scan_cnt;
  logic              rd_pend;
  logic [IW-1:0]     rd_idx;
  logic              best_found;
  logic [IW-1:0]     best_idx;
  entry_t            best;
  logic [SCW-1:0]    due_cnt;
  logic              first_round;
  logic [OUT_CW-1:0] tot;
  logic [OUT_CW-1:0] emitted;

  logic               accept_in;
  logic               in_range;
  logic [IW-1:0]      slot_idx;
  logic [TIME_W-1:0]  ival;
  logic               arm_we;
  logic               rearm_we;
  logic               out_free;
  entry_t             arm_entry;
  entry_t             rearm_entry;
  entry_t             rd_entry;
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               cand;
  logic               better;
  logic [CMPW-1:0]    due_ext;
  logic [OUT_CW-1:0]  tot_now;
  logic               last_now;

  assign item_ready = (state == S_IDLE);
  assign accept_in  = item_valid && item_ready;
  assign in_range   = int'(slot) < NUM_TIMERS;
  assign slot_idx   = IW'(slot);
  assign ival       = (interval == '0) ? TIME_W'(1) : interval;
  assign out_free   = !result_valid || result_ready;

  assign arm_we   = accept_in && (action == ACT_ARM) && in_range;
  assign rearm_we = (state == S_DECIDE) && out_free && best_found && best.repeats;

  always_comb begin
    arm_entry.trigger = sat_add(now, ival);
    arm_entry.period  = ival;
    arm_entry.repeats = repeat_req;
    arm_entry.stamp   = stamp_counter;

    rearm_entry.trigger = sat_add(now_q, best.period);
    rearm_entry.period  = best.period;
    rearm_entry.repeats = 1'b1;
    rearm_entry.stamp   = stamp_counter;
  end

  // Arms come only while idle and re-arms only in the decide cycle, so they never collide.
  assign ram_we    = arm_we || rearm_we;
  assign ram_waddr = arm_we ? slot_idx : best_idx;
  assign ram_wdata = arm_we ? arm_entry : rearm_entry;

  tes_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_TIMERS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scan_cnt[IW-1:0]),
    .rdata(ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);

  // A slot is a candidate when it is active, not yet reported this tick, and due.
  assign cand = rd_pend && active[rd_idx] && !done[rd_idx] && (rd_entry.trigger <= now_q);
  // Strict compare keeps the lowest slot number on a full tie.
  assign better = !best_found ||
                  ({rd_entry.trigger, rd_entry.stamp} < {best.trigger, best.stamp});

  // The first pass counts the due slots; that count, capped, is the number of timers reported.
  always_comb begin
    due_ext = CMPW'(due_cnt);
    if (!first_round) begin
      tot_now = tot;
    end else if (due_ext >= CMPW'(MAX_OUT)) begin
      tot_now = OUT_CW'(MAX_OUT);
    end else begin
      tot_now = OUT_CW'(due_ext);
    end
    last_now = !best_found || ((emitted + OUT_CW'(1)) == tot_now);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      active        <= '0;
      done          <= '0;
      stamp_counter <= '0;
      result_valid  <= 1'b0;
      rd_pend       <= 1'b0;
      best_found    <= 1'b0;
      first_round   <= 1'b0;
      scan_cnt      <= '0;
      due_cnt       <= '0;
      tot           <= '0;
      emitted       <= '0;
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      rd_pend <= 1'b0;

      case (state)
        S_IDLE: begin
          if (accept_in) begin
            if (arm_we) begin
              active[slot_idx] <= 1'b1;
              stamp_counter    <= stamp_counter + 1'b1;
            end
            if ((action == ACT_DELETE) && in_range) begin
              active[slot_idx] <= 1'b0;
            end
            if (action == ACT_TICK) begin
              now_q       <= now;
              done        <= '0;
              best_found  <= 1'b0;
              due_cnt     <= '0;
              scan_cnt    <= '0;
              first_round <= 1'b1;
              emitted     <= '0;
              state       <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (scan_cnt != SCW'(NUM_TIMERS)) begin
            rd_pend  <= 1'b1;
            rd_idx   <= scan_cnt[IW-1:0];
            scan_cnt <= scan_cnt + 1'b1;
          end else begin
            // The last slot is being compared in this cycle.
            state <= S_DECIDE;
          end
          if (cand) begin
            if (first_round) begin
              due_cnt <= due_cnt + 1'b1;
            end
            if (better) begin
              best_found <= 1'b1;
              best       <= rd_entry;
              best_idx   <= rd_idx;
            end
          end
        end

        S_DECIDE: begin
          tot <= tot_now;
          if (out_free) begin
            first_round  <= 1'b0;
            result_valid <= 1'b1;
            fired_valid  <= best_found;
            fired_slot   <= best_found ? SLOT_W'(best_idx) : '0;
            last         <= last_now;
            if (best_found) begin
              done[best_idx] <= 1'b1;
              emitted        <= emitted + 1'b1;
              if (best.repeats) begin
                stamp_counter <= stamp_counter + 1'b1;
              end else begin
                active[best_idx] <= 1'b0;
              end
            end
            if (last_now) begin
              state <= S_IDLE;
            end else begin
              state      <= S_SCAN;
              scan_cnt   <= '0;
              best_found <= 1'b0;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
